[sv/ttw_pkg.sv]
// shared types and constants for the text terminal writer
package ttw_pkg;

    localparam int CMD_W   = 3;
    localparam int CHAR_W  = 8;
    localparam int TCOL_W  = 8;
    localparam int TROW_W  = 6;
    localparam int COUNT_W = 8;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int OFFS_W  = 11;
    localparam int CELL_W  = 16;
    localparam int COLOR_W = 8;
    localparam int CALC_W  = 12;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_PUT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GOTO   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SCROLL = 3'd4;

    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd7;

    localparam int AUTO_MARGIN = 3;
    localparam int AUTO_SCROLL = 5;
    localparam int TAB_STEP    = 4;
    localparam logic [COL_W-1:0] TAB_MASK = ~7'd3;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_PUT,
        OP_NEWLINE,
        OP_TAB,
        OP_CR,
        OP_GOTO,
        OP_READ,
        OP_CLEAR,
        OP_SCROLL
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CHAR_W-1:0]  ch;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [COUNT_W-1:0] count;
    } req_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_stat_t;

endpackage

[sv/ttw_front.sv]
// front end: request decode, coordinate clamping and a two-entry request queue
module ttw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ttw_pkg::CMD_W-1:0]   s_cmd,
    input  logic [ttw_pkg::CHAR_W-1:0]  s_char_code,
    input  logic [ttw_pkg::TCOL_W-1:0]  s_target_col,
    input  logic [ttw_pkg::TROW_W-1:0]  s_target_row,
    input  logic [ttw_pkg::COUNT_W-1:0] s_scroll_count,
    output logic                        req_valid,
    output ttw_pkg::req_t               req,
    input  ttw_pkg::back_stat_t         stat
);
    import ttw_pkg::*;

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    req_t             q_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    req_t             in_req;
    logic             push;

    always_comb begin
        in_req.op    = OP_NOP;
        in_req.ch    = s_char_code;
        in_req.count = s_scroll_count;
        in_req.col   = (s_target_col >= TCOL_W'(COLUMNS)) ? COL_W'(COLUMNS - 1)
                                                         : s_target_col[COL_W-1:0];
        in_req.row   = (s_target_row >= TROW_W'(ROWS)) ? ROW_W'(ROWS - 1)
                                                      : s_target_row[ROW_W-1:0];
        case (s_cmd)
            CMD_PUT: begin
                case (s_char_code)
                    CH_NEWLINE: in_req.op = OP_NEWLINE;
                    CH_TAB:     in_req.op = OP_TAB;
                    CH_CR:      in_req.op = OP_CR;
                    default:    in_req.op = OP_PUT;
                endcase
            end
            CMD_GOTO:   in_req.op = OP_GOTO;
            CMD_READ:   in_req.op = OP_READ;
            CMD_CLEAR:  in_req.op = OP_CLEAR;
            CMD_SCROLL: in_req.op = OP_SCROLL;
            default:    in_req.op = OP_NOP;
        endcase
    end

    // no requests while the screen store is swept after reset
    assign s_ready   = !stat.clearing && (count_reg != CNT_W'(QDEPTH));
    assign push      = s_valid && s_ready;
    assign req_valid = (count_reg != '0);
    assign req       = q_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !stat.pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!push && stat.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (stat.pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

[sv/ttw_back.sv]
// back end: cursor, screen store, copy and blank sweeps, result register
module ttw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        req_valid,
    input  ttw_pkg::req_t               req,
    input  logic [ttw_pkg::COLOR_W-1:0] text_color,
    output ttw_pkg::back_stat_t         stat,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ttw_pkg::COL_W-1:0]   m_cursor_col,
    output logic [ttw_pkg::ROW_W-1:0]   m_cursor_row,
    output logic [ttw_pkg::OFFS_W-1:0]  m_cursor_offset,
    output logic [ttw_pkg::CELL_W-1:0]  m_cell_value
);
    import ttw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(CELLS - 1);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SWEEP, S_RESP} state_t;

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;

    state_t            state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] off_reg, off_next;
    logic [ADDR_W-1:0] limit_reg, limit_next;
    logic [CELL_W-1:0] blank_reg, blank_next;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic              wr_pend_reg, wr_copy_reg;

    logic              m_valid_reg;
    logic [COL_W-1:0]  m_col_reg;
    logic [ROW_W-1:0]  m_row_reg;
    logic [OFFS_W-1:0] m_offset_reg;
    logic [CELL_W-1:0] m_cell_reg;

    logic              put_we, rd_go, sweep_go, sweep_all, load_out;
    logic [ROW_W-1:0]  scroll_rows;
    logic [COL_W:0]    col_inc, tab_sum;
    logic [ROW_W:0]    row_inc, put_row;
    logic [CALC_W-1:0] cur_lin, read_lin, off_calc;
    logic [ADDR_W:0]   lim_calc;
    logic              sweeping, copy_now;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_wa, mem_ra;
    logic [CELL_W-1:0] mem_wd;

    assign cur_lin  = CALC_W'(row_reg) * CALC_W'(COLUMNS) + CALC_W'(col_reg);
    assign read_lin = CALC_W'(req.row) * CALC_W'(COLUMNS) + CALC_W'(req.col);
    assign col_inc  = {1'b0, col_reg} + (COL_W+1)'(1);
    assign tab_sum  = {1'b0, col_reg & TAB_MASK} + (COL_W+1)'(TAB_STEP);
    assign row_inc  = {1'b0, row_reg} + (ROW_W+1)'(1);
    assign put_row  = (row_inc >= (ROW_W+1)'(ROWS)) ? '0 : row_inc;
    assign off_calc = CALC_W'(scroll_rows) * CALC_W'(COLUMNS);
    assign lim_calc = (ADDR_W+1)'(CELLS) - {1'b0, off_calc[ADDR_W-1:0]};

    always_comb begin
        state_next  = state_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        idx_next    = idx_reg;
        off_next    = off_reg;
        limit_next  = limit_reg;
        blank_next  = blank_reg;
        put_we      = 1'b0;
        rd_go       = 1'b0;
        sweep_go    = 1'b0;
        sweep_all   = 1'b0;
        scroll_rows = ROW_W'(AUTO_SCROLL);
        load_out    = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                // hold off while the last sweep write still owns the write port
                if (req_valid && !wr_pend_reg) begin
                    state_next = S_RESP;
                    case (req.op)
                        OP_PUT: begin
                            put_we = 1'b1;
                            if (col_inc >= (COL_W+1)'(COLUMNS)) begin
                                col_next = '0;
                                if ((put_row + (ROW_W+1)'(AUTO_MARGIN)) > (ROW_W+1)'(ROWS)) begin
                                    sweep_go = 1'b1;
                                    row_next = ROW_W'(put_row - (ROW_W+1)'(AUTO_SCROLL));
                                end else begin
                                    row_next = put_row[ROW_W-1:0];
                                end
                            end else begin
                                col_next = col_inc[COL_W-1:0];
                            end
                        end
                        OP_NEWLINE: begin
                            if ((row_inc + (ROW_W+1)'(AUTO_MARGIN)) > (ROW_W+1)'(ROWS)) begin
                                sweep_go = 1'b1;
                                row_next = ROW_W'(row_inc - (ROW_W+1)'(AUTO_SCROLL));
                            end else begin
                                row_next = row_inc[ROW_W-1:0];
                            end
                        end
                        OP_TAB: begin
                            col_next = (tab_sum >= (COL_W+1)'(COLUMNS)) ? COL_W'(COLUMNS - 1)
                                                                       : tab_sum[COL_W-1:0];
                        end
                        OP_CR: begin
                            col_next = '0;
                        end
                        OP_GOTO: begin
                            col_next = req.col;
                            row_next = req.row;
                        end
                        OP_READ: begin
                            rd_go = 1'b1;
                        end
                        OP_CLEAR: begin
                            sweep_go  = 1'b1;
                            sweep_all = 1'b1;
                            col_next  = '0;
                            row_next  = '0;
                        end
                        OP_SCROLL: begin
                            if (req.count >= COUNT_W'(ROWS)) begin
                                sweep_go  = 1'b1;
                                sweep_all = 1'b1;
                                row_next  = '0;
                            end else if (req.count != '0) begin
                                sweep_go    = 1'b1;
                                scroll_rows = req.count[ROW_W-1:0];
                                row_next    = (row_reg > req.count[ROW_W-1:0])
                                            ? row_reg - req.count[ROW_W-1:0] : '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (sweep_go) begin
                        state_next = S_SWEEP;
                        idx_next   = '0;
                        off_next   = off_calc[ADDR_W-1:0];
                        limit_next = sweep_all ? '0 : lim_calc[ADDR_W-1:0];
                        blank_next = {text_color, CH_SPACE};
                    end
                end
            end
            S_SWEEP: begin
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = S_RESP;
                end else begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // sweep reads the source row ahead, the write lands in the next cycle
    assign sweeping = (state_reg == S_SWEEP) || (state_reg == S_CLEAR);
    assign copy_now = sweeping && (idx_reg < limit_reg);
    assign mem_re   = copy_now || rd_go;
    assign mem_ra   = copy_now ? idx_reg + off_reg : read_lin[ADDR_W-1:0];
    assign mem_we   = wr_pend_reg || put_we;
    assign mem_wa   = wr_pend_reg ? wr_addr_reg : cur_lin[ADDR_W-1:0];
    assign mem_wd   = wr_pend_reg ? (wr_copy_reg ? rd_data_reg : blank_reg)
                                  : {text_color, req.ch};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            col_reg     <= '0;
            row_reg     <= '0;
            idx_reg     <= '0;
            off_reg     <= '0;
            limit_reg   <= '0;
            blank_reg   <= {RESET_COLOR, CH_SPACE};
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            idx_reg     <= idx_next;
            off_reg     <= off_next;
            limit_reg   <= limit_next;
            blank_reg   <= blank_next;
            wr_pend_reg <= sweeping;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        wr_addr_reg <= idx_reg;
        wr_copy_reg <= copy_now;
        if (load_out) begin
            m_col_reg    <= col_reg;
            m_row_reg    <= row_reg;
            m_offset_reg <= cur_lin[OFFS_W-1:0];
            m_cell_reg   <= (req.op == OP_READ) ? rd_data_reg : '0;
        end
    end

    assign stat.pop         = load_out;
    assign stat.clearing    = (state_reg == S_CLEAR);
    assign m_valid          = m_valid_reg;
    assign m_cursor_col     = m_col_reg;
    assign m_cursor_row     = m_row_reg;
    assign m_cursor_offset  = m_offset_reg;
    assign m_cell_value     = m_cell_reg;

endmodule

[sv/text_terminal_writer_top.sv]
// a request's result is registered by the back end's result step, after the queue and execute steps
// the back end starts a new request only after the execute and result steps of the last one
// clear, scroll and any auto-scroll walk the screen store one cell per cycle
// reset: synchronous active-low; then a pass over the store blanks it to 0x0720,
// with s_ready low; configuration writes are taken during that pass
module text_terminal_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ttw_pkg::CMD_W-1:0]      s_cmd,
    input  logic [ttw_pkg::CHAR_W-1:0]     s_char_code,
    input  logic [ttw_pkg::TCOL_W-1:0]     s_target_col,
    input  logic [ttw_pkg::TROW_W-1:0]     s_target_row,
    input  logic [ttw_pkg::COUNT_W-1:0]    s_scroll_count,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ttw_pkg::COL_W-1:0]      m_cursor_col,
    output logic [ttw_pkg::ROW_W-1:0]      m_cursor_row,
    output logic [ttw_pkg::OFFS_W-1:0]     m_cursor_offset,
    output logic [ttw_pkg::CELL_W-1:0]     m_cell_value,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ttw_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ttw_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ttw_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import ttw_pkg::*;

    logic [COLOR_W-1:0] color_reg;
    logic               cfg_we;
    logic               req_valid;
    req_t               req;
    back_stat_t         stat;

    // register index sits above the byte offset
    assign cfg_we = psel && penable && pwrite && !paddr[APB_ADDR_W-1];
    assign pready = 1'b1;
    assign prdata = paddr[APB_ADDR_W-1] ? '0 : APB_DATA_W'(color_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg <= RESET_COLOR;
        end else if (cfg_we) begin
            color_reg <= pwdata[COLOR_W-1:0];
        end
    end

    ttw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_char_code    (s_char_code),
        .s_target_col   (s_target_col),
        .s_target_row   (s_target_row),
        .s_scroll_count (s_scroll_count),
        .req_valid      (req_valid),
        .req            (req),
        .stat           (stat)
    );

    ttw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .req_valid       (req_valid),
        .req             (req),
        .text_color      (color_reg),
        .stat            (stat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cursor_col    (m_cursor_col),
        .m_cursor_row    (m_cursor_row),
        .m_cursor_offset (m_cursor_offset),
        .m_cell_value    (m_cell_value)
    );

endmodule

[sv/ttw_checker.sv]
// port-level checks for the text terminal writer, bound to the top level
module ttw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [ttw_pkg::COL_W-1:0]     m_cursor_col,
    input logic [ttw_pkg::ROW_W-1:0]     m_cursor_row,
    input logic [ttw_pkg::OFFS_W-1:0]    m_cursor_offset
);
    import ttw_pkg::*;

    logic [CALC_W-1:0] exp_lin;

    assign exp_lin = CALC_W'(m_cursor_row) * CALC_W'(COLUMNS) + CALC_W'(m_cursor_col);

    a_cursor_in_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((COL_W+1)'(m_cursor_col) < (COL_W+1)'(COLUMNS))
                    && ((ROW_W+1)'(m_cursor_row) < (ROW_W+1)'(ROWS)))
        else $error("cursor outside the screen");

    a_offset_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cursor_offset == exp_lin[OFFS_W-1:0]))
        else $error("cursor offset does not match row and column");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cursor_offset))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind text_terminal_writer_top ttw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_ttw_checker (.*);
